// ===== sv/btxc_pkg.sv =====
// Package for the binary xor trie counter.
// Holds opcodes, field widths and the controller/datapath command and status structs.
// No dependencies.
package btxc_pkg;

   localparam int OPCODE_W = 2;
   localparam int KEY_W    = 32;
   localparam int PLEN_W   = 6;
   localparam int LIMIT_W  = 32;
   localparam int COUNT_W  = 32;

   localparam logic [OPCODE_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_SEARCH = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_QUERY  = 2'd2;

   // Controller to datapath.
   typedef struct packed {
      logic init_root;    // write the root node with empty links and zero count
      logic read_root;    // point the node read port at the root
      logic load;         // capture a new request
      logic walk;         // perform the writes for the current trie level
      logic descend;      // step to the next level, allocating on insert
      logic capture;      // take the current node count as the search result
      logic emit;         // load the response register
      logic status_full;  // response status: node pool ran out
   } ctl_cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic [OPCODE_W-1:0] op;
      logic                at_end;
      logic                child_missing;
      logic                pool_full;
   } dp_status_type;

endpackage

// ===== sv/btxc_if.sv =====
// Valid/ready channel interfaces for requests and responses.
// Depends on btxc_pkg for the field widths.
interface btxc_req_if import btxc_pkg::*; ;
   logic                valid;
   logic                ready;
   logic [OPCODE_W-1:0] opcode;
   logic [KEY_W-1:0]    key;
   logic [PLEN_W-1:0]   prefix_len;
   logic [LIMIT_W-1:0]  limit;

   modport source (output valid, opcode, key, prefix_len, limit, input ready);
   modport sink (input valid, opcode, key, prefix_len, limit, output ready);
endinterface

interface btxc_rsp_if import btxc_pkg::*; ;
   logic               valid;
   logic               ready;
   logic [COUNT_W-1:0] count;
   logic               status;

   modport source (output valid, count, status, input ready);
   modport sink (input valid, count, status, output ready);
endinterface

// ===== sv/btxc_dp.sv =====
// Datapath of the binary xor trie counter: node memories, walk registers,
// node allocator, saturating accumulator and response payload register.
// Depends on btxc_pkg.
module btxc_dp import btxc_pkg::*; #(
   parameter int KEY_BITS   = 32,
   parameter int NODE_COUNT = 4096
) (
   input  logic                clock,
   input  logic                reset,
   input  ctl_cmd_type         cmd,
   output dp_status_type       status,
   input  logic [OPCODE_W-1:0] req_opcode,
   input  logic [KEY_W-1:0]    req_key,
   input  logic [PLEN_W-1:0]   req_prefix_len,
   input  logic [LIMIT_W-1:0]  req_limit,
   output logic [COUNT_W-1:0]  rsp_count,
   output logic                rsp_status
);

   localparam int NODE_W  = $clog2(NODE_COUNT);
   localparam int FREE_W  = $clog2(NODE_COUNT + 1);
   localparam int DEPTH_W = $clog2(KEY_BITS + 1);

   function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] a);
      return (a == '1) ? a : a + COUNT_W'(1);
   endfunction

   function automatic logic [COUNT_W-1:0] sat_add(input logic [COUNT_W-1:0] a,
                                                  input logic [COUNT_W-1:0] b);
      logic [COUNT_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[COUNT_W] ? '1 : s[COUNT_W-1:0];
   endfunction

   // Node pool.
   logic [NODE_W-1:0]  zero_mem  [NODE_COUNT];
   logic [NODE_W-1:0]  one_mem   [NODE_COUNT];
   logic [COUNT_W-1:0] count_mem [NODE_COUNT];

   logic [NODE_W-1:0]  zero_rd_ff, one_rd_ff;
   logic [COUNT_W-1:0] cnt_a_rd_ff, cnt_b_rd_ff;

   logic [OPCODE_W-1:0] op_ff, op_in;
   logic [KEY_BITS-1:0] key_ff, key_in;
   logic [KEY_BITS-1:0] limit_ff, limit_in;
   logic [DEPTH_W-1:0]  target_ff, target_in;
   logic [DEPTH_W-1:0]  depth_ff, depth_in;
   logic [NODE_W-1:0]   cur_ff, cur_in;
   logic                fresh_ff, fresh_in;
   logic [FREE_W-1:0]   next_free_ff, next_free_in;
   logic [COUNT_W-1:0]  sum_ff, sum_in;
   logic                pending_ff, pending_in;
   logic [COUNT_W-1:0]  rsp_count_ff, rsp_count_in;
   logic                rsp_status_ff, rsp_status_in;

   logic                kb, lb, is_ins, is_qry, at_end, pool_full, child_missing, alloc;
   logic                link_ok, fresh_wr, ext_link_wr;
   logic [NODE_W-1:0]   same, other, child, link_val, wr_addr, rd_addr;
   logic                zero_we, one_we, cnt_we;
   logic [NODE_W-1:0]   zero_wdata, one_wdata;
   logic [COUNT_W-1:0]  cnt_wdata, sum_base;
   logic [DEPTH_W-1:0]  plen_clamped;

   assign kb        = key_ff[KEY_BITS-1];
   assign lb        = limit_ff[KEY_BITS-1];
   assign is_ins    = (op_ff == OP_INSERT);
   assign is_qry    = (op_ff == OP_QUERY);
   assign same      = kb ? one_rd_ff : zero_rd_ff;
   assign other     = kb ? zero_rd_ff : one_rd_ff;
   // The xor query follows the opposite branch wherever the limit bit is one.
   assign child     = (is_qry && lb) ? other : same;
   assign at_end    = (depth_ff == target_ff);
   assign pool_full = (next_free_ff == FREE_W'(NODE_COUNT));
   // A freshly allocated node has no children yet, and its memory read is stale.
   assign child_missing = fresh_ff || (child == '0);
   assign alloc     = cmd.descend && is_ins && child_missing;
   assign link_val  = next_free_ff[NODE_W-1:0];

   // Write side. A fresh node gets its final links at once: a chain of new nodes
   // is allocated consecutively, so its one link is the next free index.
   assign fresh_wr    = cmd.walk && is_ins && fresh_ff;
   assign ext_link_wr = alloc && !fresh_ff;
   assign link_ok     = !cmd.init_root && (!fresh_ff || !(at_end || pool_full));
   assign wr_addr     = cmd.init_root ? '0 : cur_ff;
   assign zero_we     = cmd.init_root || fresh_wr || (ext_link_wr && !kb);
   assign one_we      = cmd.init_root || fresh_wr || (ext_link_wr && kb);
   assign zero_wdata  = (link_ok && !kb) ? link_val : '0;
   assign one_wdata   = (link_ok && kb) ? link_val : '0;
   // The root is never counted; every other node on an insert path is.
   assign cnt_we      = cmd.init_root ||
                        (cmd.walk && is_ins && (fresh_ff || depth_ff != '0));
   assign cnt_wdata   = cmd.init_root ? '0 :
                        fresh_ff ? COUNT_W'(1) : sat_inc(cnt_a_rd_ff);
   assign rd_addr     = cmd.read_root ? '0 : child;

   always_ff @(posedge clock) begin
      if (zero_we) zero_mem[wr_addr] <= zero_wdata;
      if (one_we) one_mem[wr_addr] <= one_wdata;
      if (cnt_we) count_mem[wr_addr] <= cnt_wdata;
      zero_rd_ff  <= zero_mem[rd_addr];
      one_rd_ff   <= one_mem[rd_addr];
      cnt_a_rd_ff <= count_mem[rd_addr];
      cnt_b_rd_ff <= count_mem[same];
   end

   always_comb begin
      if ({1'b0, req_prefix_len} > 7'(KEY_BITS)) begin
         plen_clamped = DEPTH_W'(KEY_BITS);
      end else begin
         plen_clamped = DEPTH_W'(req_prefix_len);
      end
   end

   // The count of the matching branch arrives in the cycle after its read.
   assign sum_base = pending_ff ? sat_add(sum_ff, cnt_b_rd_ff) : sum_ff;

   always_comb begin
      op_in        = op_ff;
      key_in       = key_ff;
      limit_in     = limit_ff;
      target_in    = target_ff;
      depth_in     = depth_ff;
      cur_in       = cur_ff;
      fresh_in     = fresh_ff;
      next_free_in = next_free_ff;
      sum_in       = sum_base;
      pending_in   = cmd.walk && is_qry && lb && !at_end && (same != '0);
      if (cmd.load) begin
         op_in     = req_opcode;
         key_in    = KEY_BITS'(req_key);
         limit_in  = KEY_BITS'(req_limit);
         target_in = (req_opcode == OP_SEARCH) ? plen_clamped : DEPTH_W'(KEY_BITS);
         depth_in  = '0;
         cur_in    = '0;
         fresh_in  = 1'b0;
         sum_in    = '0;
         pending_in = 1'b0;
      end else if (cmd.descend) begin
         key_in   = key_ff << 1;
         limit_in = limit_ff << 1;
         depth_in = depth_ff + DEPTH_W'(1);
         cur_in   = alloc ? link_val : child;
         fresh_in = alloc;
      end
      if (cmd.capture) begin
         sum_in = cnt_a_rd_ff;
      end
      if (alloc) begin
         next_free_in = next_free_ff + FREE_W'(1);
      end
      rsp_count_in  = rsp_count_ff;
      rsp_status_in = rsp_status_ff;
      if (cmd.emit) begin
         rsp_count_in  = sum_in;
         rsp_status_in = cmd.status_full;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fresh_ff     <= 1'b0;
         pending_ff   <= 1'b0;
         next_free_ff <= FREE_W'(1);
      end else begin
         fresh_ff     <= fresh_in;
         pending_ff   <= pending_in;
         next_free_ff <= next_free_in;
      end
      op_ff         <= op_in;
      key_ff        <= key_in;
      limit_ff      <= limit_in;
      target_ff     <= target_in;
      depth_ff      <= depth_in;
      cur_ff        <= cur_in;
      sum_ff        <= sum_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign status.op            = op_ff;
   assign status.at_end        = at_end;
   assign status.child_missing = child_missing;
   assign status.pool_full     = pool_full;

   assign rsp_count  = rsp_count_ff;
   assign rsp_status = rsp_status_ff;

endmodule

// ===== sv/btxc_ctrl.sv =====
// Controller of the binary xor trie counter: root setup after reset, request
// intake, per-level walk decisions and the response handshake.
// Depends on btxc_pkg.
module btxc_ctrl import btxc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  dp_status_type status,
   output ctl_cmd_type   cmd
);

   localparam logic [1:0] ST_INIT = 2'd0;
   localparam logic [1:0] ST_IDLE = 2'd1;
   localparam logic [1:0] ST_WALK = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       full_ff, full_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      full_in      = full_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      cmd.status_full = full_ff;
      unique case (state_ff)
         ST_INIT: begin
            cmd.init_root = 1'b1;
            state_in      = ST_IDLE;
         end
         ST_IDLE: begin
            cmd.read_root = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               full_in  = 1'b0;
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            cmd.walk = 1'b1;
            unique case (status.op)
               OP_INSERT: begin
                  if (status.at_end) begin
                     state_in = ST_DONE;
                  end else if (status.child_missing && status.pool_full) begin
                     full_in  = 1'b1;
                     state_in = ST_DONE;
                  end else begin
                     cmd.descend = 1'b1;
                  end
               end
               OP_SEARCH: begin
                  if (status.at_end) begin
                     cmd.capture = 1'b1;
                     state_in    = ST_DONE;
                  end else if (status.child_missing) begin
                     state_in = ST_DONE;
                  end else begin
                     cmd.descend = 1'b1;
                  end
               end
               OP_QUERY: begin
                  if (status.at_end || status.child_missing) begin
                     state_in = ST_DONE;
                  end else begin
                     cmd.descend = 1'b1;
                  end
               end
               default: begin
                  state_in = ST_DONE;
               end
            endcase
         end
         ST_DONE: begin
            // Wait here while the previous response is still held.
            if (out_free) begin
               cmd.emit     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         full_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         full_ff      <= full_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== sv/binary_trie_xor_count.sv =====
// Binary xor trie counter: insert, prefix count and xor-below-limit count.
// Requests are handled one at a time: a new request is taken only after the
// response to the previous one is loaded. The trie levels walked are KEY_BITS
// for insert and a full query and prefix_len for search; one node memory read
// per level sets the rate, and a held response stalls it. After reset the root
// node is written in the init state, during which no request is taken.
module binary_trie_xor_count import btxc_pkg::*; #(
   parameter int KEY_BITS   = 32,
   parameter int NODE_COUNT = 4096
) (
   input logic       clock,
   input logic       reset,
   btxc_req_if.sink  req_chan,
   btxc_rsp_if.source rsp_chan
);

   ctl_cmd_type   cmd;
   dp_status_type status;

   btxc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   btxc_dp #(
      .KEY_BITS   (KEY_BITS),
      .NODE_COUNT (NODE_COUNT)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_opcode     (req_chan.opcode),
      .req_key        (req_chan.key),
      .req_prefix_len (req_chan.prefix_len),
      .req_limit      (req_chan.limit),
      .rsp_count      (rsp_chan.count),
      .rsp_status     (rsp_chan.status)
   );

endmodule

// ===== dv/tb_binary_trie_xor_count.sv =====
// Self-checking testbench for binary_trie_xor_count: directed and random insert, prefix
// search and xor-below-limit requests, with a trie scoreboard that predicts every response.
// Depends on btxc_pkg and the channel interfaces in btxc_if.
module tb_binary_trie_xor_count;
   timeunit 1ns;
   timeprecision 1ps;
   import btxc_pkg::*;

   localparam int TRIE_KEY_BITS = 32;
   localparam int POOL_NODES    = 4096;
   localparam int LINK_W        = $clog2(POOL_NODES);
   localparam int RANDOM_ITEMS  = 1330;
   localparam int FLOOD_FIRST   = 900;
   localparam int FLOOD_LAST    = 1000;
   localparam int FAMILIES      = 6;
   localparam int HOLD_AT       = 400;
   localparam int HOLD_CYCLES   = 700;
   localparam int DRAIN_CYCLES  = 60;
   localparam int CYCLE_LIMIT   = 600000;
   localparam int MAX_REPORTS   = 10;

   localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

   typedef struct packed {
      logic [COUNT_W-1:0] count;
      logic               status;
   } trie_answer_type;

   // Shadow trie: predicts each response from the requests that were transferred.
   class trie_count_board;
      bit [LINK_W-1:0]  zero_link [POOL_NODES];
      bit [LINK_W-1:0]  one_link [POOL_NODES];
      bit [COUNT_W-1:0] visits [POOL_NODES];
      int               next_free;
      trie_answer_type  awaited_answers [$];
      int               errors;

      function new();
         zero_link[0] = '0;
         one_link[0]  = '0;
         visits[0]    = '0;
         next_free    = 1;
         errors       = 0;
      endfunction

      function bit walk_insert(logic [KEY_W-1:0] key);
         int node;
         int c;
         bit b;
         node = 0;
         for (int i = 0; i < TRIE_KEY_BITS; i++) begin
            b = key[TRIE_KEY_BITS-1-i];
            c = b ? one_link[node] : zero_link[node];
            if (c == 0) begin
               // The walk stops at the first node that cannot be allocated.
               if (next_free >= POOL_NODES) return 1'b1;
               c = next_free;
               next_free++;
               zero_link[c] = '0;
               one_link[c]  = '0;
               visits[c]    = '0;
               if (b) one_link[node] = LINK_W'(c);
               else zero_link[node] = LINK_W'(c);
            end
            node = c;
            if (visits[node] != '1) visits[node] += 1;
         end
         return 1'b0;
      endfunction

      function logic [COUNT_W-1:0] prefix_tally(logic [KEY_W-1:0] key,
                                                logic [PLEN_W-1:0] plen);
         int node;
         int c;
         int depth;
         node  = 0;
         depth = (plen > TRIE_KEY_BITS) ? TRIE_KEY_BITS : int'(plen);
         for (int i = 0; i < depth; i++) begin
            c = key[TRIE_KEY_BITS-1-i] ? one_link[node] : zero_link[node];
            if (c == 0) return '0;
            node = c;
         end
         return visits[node];
      endfunction

      function logic [COUNT_W-1:0] xor_tally(logic [KEY_W-1:0] key,
                                             logic [LIMIT_W-1:0] lim);
         int               node;
         int               c;
         int               same;
         bit               kb;
         bit [COUNT_W:0]   wide;
         bit [COUNT_W-1:0] sum;
         node = 0;
         sum  = '0;
         for (int i = 0; i < TRIE_KEY_BITS; i++) begin
            kb = key[TRIE_KEY_BITS-1-i];
            if (lim[TRIE_KEY_BITS-1-i]) begin
               // Keys on the matching side have a zero xor bit here, so all lie below the limit.
               same = kb ? one_link[node] : zero_link[node];
               if (same != 0) begin
                  wide = {1'b0, sum} + visits[same];
                  sum  = wide[COUNT_W] ? '1 : wide[COUNT_W-1:0];
               end
               c = kb ? zero_link[node] : one_link[node];
            end else begin
               c = kb ? one_link[node] : zero_link[node];
            end
            if (c == 0) break;
            node = c;
         end
         return sum;
      endfunction

      function void note_request(logic [OPCODE_W-1:0] op, logic [KEY_W-1:0] key,
                                 logic [PLEN_W-1:0] plen, logic [LIMIT_W-1:0] lim);
         trie_answer_type ans;
         ans.count  = '0;
         ans.status = 1'b0;
         case (op)
            OP_INSERT: ans.status = walk_insert(key);
            OP_SEARCH: ans.count = prefix_tally(key, plen);
            OP_QUERY: ans.count = xor_tally(key, lim);
            default: ;
         endcase
         awaited_answers.push_back(ans);
      endfunction

      function void check_response(logic [COUNT_W-1:0] count, logic status);
         trie_answer_type ans;
         if (awaited_answers.size() == 0) begin
            if (errors < MAX_REPORTS)
               $display("unexpected response: count %h status %0d", count, status);
            errors++;
         end else begin
            ans = awaited_answers.pop_front();
            if (ans.count !== count || ans.status !== status) begin
               if (errors < MAX_REPORTS)
                  $display("response mismatch: expected count %h status %0d, got count %h status %0d",
                           ans.count, ans.status, count, status);
               errors++;
            end
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   btxc_req_if req_if ();
   btxc_rsp_if rsp_if ();

   trie_count_board board = new();

   logic [KEY_W-1:0] family_base [FAMILIES];
   logic [KEY_W-1:0] seen_keys [$];
   bit               calm_send = 1'b0;
   int               sent_count = 0;
   int               cycle_count = 0;

   binary_trie_xor_count #(
      .KEY_BITS(TRIE_KEY_BITS),
      .NODE_COUNT(POOL_NODES)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_if),
      .rsp_chan(rsp_if)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Mostly short gaps, now and then a long one.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Keys mostly come from a few families so that paths are shared and the pool lasts.
   function automatic logic [KEY_W-1:0] pick_key();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60)
         return family_base[$urandom_range(0, FAMILIES-1)] ^
                (32'($urandom) & ((32'(1) << $urandom_range(0, 6)) - 32'(1)));
      if (roll < 88 && seen_keys.size() > 0)
         return seen_keys[$urandom_range(0, seen_keys.size()-1)];
      return $urandom;
   endfunction

   task automatic send_request(input logic [OPCODE_W-1:0] op, input logic [KEY_W-1:0] key,
                               input logic [PLEN_W-1:0] plen, input logic [LIMIT_W-1:0] lim);
      int gap;
      gap = calm_send ? 0 : pick_gap();
      if (gap > 0) begin
         req_if.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid      = 1'b1;
      req_if.opcode     = op;
      req_if.key        = key;
      req_if.prefix_len = plen;
      req_if.limit      = lim;
      do @(posedge clock); while (!req_if.ready);
      board.note_request(op, key, plen, lim);
      sent_count++;
      @(negedge clock);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready)
         board.check_response(rsp_if.count, rsp_if.status);
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_binary_trie_xor_count failed");
         $finish;
      end
   end

   // Response side: random stalls, calm stretches, and one long hold-off that backs up the input.
   initial begin
      int stall_left;
      int calm_left;
      bit held;
      stall_left   = 0;
      calm_left    = 0;
      held         = 1'b0;
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (!held && sent_count >= HOLD_AT) begin
            held       = 1'b1;
            stall_left = HOLD_CYCLES;
         end
         if (stall_left > 0) begin
            rsp_if.ready = 1'b0;
            stall_left--;
         end else begin
            rsp_if.ready = 1'b1;
            if (calm_left > 0) calm_left--;
            else if ($urandom_range(0, 999) < 4) calm_left = $urandom_range(100, 400);
            else if ($urandom_range(0, 99) < 20) stall_left = pick_gap();
         end
      end
   end

   initial begin
      reset             = 1'b1;
      req_if.valid      = 1'b0;
      req_if.opcode     = OP_INSERT;
      req_if.key        = '0;
      req_if.prefix_len = '0;
      req_if.limit      = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int i = 0; i < FAMILIES; i++) family_base[i] = $urandom;

      // Empty trie first, then the key extremes and each corner of search and query.
      send_request(OP_SEARCH, 32'h0000_0000, 6'd0, 32'h0);
      send_request(OP_QUERY, 32'h0000_0000, 6'd0, 32'hFFFF_FFFF);
      send_request(OP_INSERT, 32'h0000_0000, 6'd0, 32'h0);
      send_request(OP_INSERT, 32'hFFFF_FFFF, 6'd63, 32'hFFFF_FFFF);
      send_request(OP_INSERT, 32'hFFFF_FFFF, 6'd0, 32'h0);
      send_request(OP_INSERT, 32'h8000_0000, 6'd0, 32'h0);
      send_request(OP_INSERT, 32'h5555_5555, 6'd0, 32'h0);
      send_request(OP_SEARCH, 32'hFFFF_FFFF, 6'd32, 32'h0);
      send_request(OP_SEARCH, 32'hFFFF_FFFF, 6'd63, 32'h0);
      send_request(OP_SEARCH, 32'hFFFF_FFFF, 6'd33, 32'h0);
      send_request(OP_SEARCH, 32'hFFFF_FFFF, 6'd0, 32'h0);
      send_request(OP_SEARCH, 32'h1234_5678, 6'd32, 32'h0);
      send_request(OP_SEARCH, 32'h8000_0000, 6'd1, 32'h0);
      send_request(OP_SEARCH, 32'h0000_0000, 6'd16, 32'h0);
      send_request(OP_QUERY, 32'h0000_0000, 6'd0, 32'h0000_0000);
      send_request(OP_QUERY, 32'h0000_0000, 6'd0, 32'hFFFF_FFFF);
      send_request(OP_QUERY, 32'hFFFF_FFFF, 6'd0, 32'hFFFF_FFFF);
      send_request(OP_QUERY, 32'hAAAA_AAAA, 6'd0, 32'h5555_5555);
      send_request(OP_QUERY, 32'h7FFF_FFFF, 6'd0, 32'h8000_0000);
      send_request(OP_QUERY, 32'h5555_5555, 6'd0, 32'h0000_0001);
      send_request(OP_UNUSED, 32'hFFFF_FFFF, 6'd63, 32'hFFFF_FFFF);
      send_request(OP_UNUSED, 32'h0000_0000, 6'd0, 32'h0);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         logic [OPCODE_W-1:0] op;
         logic [KEY_W-1:0]    key;
         logic [PLEN_W-1:0]   plen;
         logic [LIMIT_W-1:0]  lim;
         int                  roll;
         calm_send = ((n % 170) < 35);
         roll = $urandom_range(0, 99);
         if (n >= FLOOD_FIRST && n < FLOOD_LAST) begin
            // A run of unrelated keys drains the node pool; later inserts run against a full pool.
            op  = OP_INSERT;
            key = $urandom;
         end else begin
            op  = (roll < 40) ? OP_INSERT : (roll < 65) ? OP_SEARCH :
                  (roll < 95) ? OP_QUERY : OP_UNUSED;
            key = pick_key();
         end
         roll = $urandom_range(0, 99);
         if (roll < 35) plen = 6'($urandom_range(0, 32));
         else if (roll < 65) plen = 6'(TRIE_KEY_BITS);
         else if (roll < 80) plen = 6'($urandom_range(33, 63));
         else plen = 6'($urandom_range(24, 32));
         roll = $urandom_range(0, 99);
         if (roll < 25) lim = $urandom;
         else if (roll < 55) lim = (key ^ pick_key()) + 32'($urandom_range(0, 2)) - 32'(1);
         else if (roll < 75) lim = 32'(1) << $urandom_range(0, 31);
         else if (roll < 85) lim = roll[0] ? '1 : '0;
         else lim = 32'($urandom) & ((32'(1) << $urandom_range(1, 31)) - 32'(1));
         if (op == OP_INSERT) seen_keys.push_back(key);
         send_request(op, key, plen, lim);
      end
      req_if.valid = 1'b0;

      while (board.awaited_answers.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.errors == 0 && board.awaited_answers.size() == 0)
         $display("tb_binary_trie_xor_count passed");
      else
         $display("tb_binary_trie_xor_count failed");
      $finish;
   end

endmodule
